@@ rtl/core/emfd_pkg.sv @@
package emfd_pkg;

	localparam int FRAME_BYTES_DEF = 23;
	localparam logic [7:0] HEADER_BYTE = 8'h55;
	localparam int GAIN_W = 28;
	localparam logic [28:0] FREQ_NUM = 29'd500000000;
	localparam logic [28:0] FREQ_ZERO_PERIOD = 29'd50000;
	localparam logic [21:0] VOLT_MAX = 22'h3FFFFF;
	localparam logic [19:0] CURR_MAX = 20'hFFFFF;
	localparam logic [24:0] POW_POS_MAX = 25'h1FFFFFF;
	localparam logic [25:0] POW_NEG_MAX = 26'h2000000;
	localparam logic [26:0] ENER_MAX = 27'h7FFFFFF;

	localparam logic [1:0] REG_VOLTAGE = 2'd0;
	localparam logic [1:0] REG_CURRENT = 2'd1;
	localparam logic [1:0] REG_POWER = 2'd2;
	localparam logic [1:0] REG_ENERGY = 2'd3;

	// One classified frame handed from the front to the back.
	typedef struct packed {
		logic        bad;
		logic [23:0] current_raw;
		logic [23:0] voltage_raw;
		logic [23:0] power_raw;
		logic [23:0] energy_raw;
		logic [15:0] period_raw;
	} frame_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_VOLT, ST_CURR, ST_POW, ST_ENER, ST_DIV, ST_OUT
	} back_state_t;

endpackage

@@ rtl/core/emfd_front.sv @@
module emfd_front #(
	parameter int FRAME_BYTES = emfd_pkg::FRAME_BYTES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [7:0]       in_byte,
	output logic             frm_valid,
	output emfd_pkg::frame_t frm
);
	import emfd_pkg::*;

	localparam logic [4:0] LAST_IDX = 5'(FRAME_BYTES - 1);

	logic        in_frame_q;
	logic [4:0]  idx_q;
	logic [7:0]  sum_q;
	logic [23:0] cur_q, vol_q, pow_q, ene_q;
	logic [15:0] per_q;

	// Hunt for the header, then accumulate and latch fields by position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			idx_q <= '0;
			sum_q <= '0;
			cur_q <= '0; vol_q <= '0; pow_q <= '0; ene_q <= '0; per_q <= '0;
		end else if (in_valid) begin
			if (!in_frame_q) begin
				if (in_byte == HEADER_BYTE) begin
					in_frame_q <= 1'b1;
					idx_q <= 5'd1;
					sum_q <= in_byte;
				end
			end else if (idx_q < LAST_IDX) begin
				sum_q <= sum_q + in_byte;
				idx_q <= idx_q + 5'd1;
				case (idx_q)
					5'd1: cur_q[7:0] <= in_byte;
					5'd2: cur_q[15:8] <= in_byte;
					5'd3: cur_q[23:16] <= in_byte;
					5'd4: vol_q[7:0] <= in_byte;
					5'd5: vol_q[15:8] <= in_byte;
					5'd6: vol_q[23:16] <= in_byte;
					5'd10: pow_q[7:0] <= in_byte;
					5'd11: pow_q[15:8] <= in_byte;
					5'd12: pow_q[23:16] <= in_byte;
					5'd13: ene_q[7:0] <= in_byte;
					5'd14: ene_q[15:8] <= in_byte;
					5'd15: ene_q[23:16] <= in_byte;
					5'd16: per_q[7:0] <= in_byte;
					5'd17: per_q[15:8] <= in_byte;
					default: ;
				endcase
			end else begin
				in_frame_q <= 1'b0;
				idx_q <= '0;
			end
		end
	end

	// The checksum byte completes a frame.
	assign frm_valid = in_valid && in_frame_q && (idx_q >= LAST_IDX);
	assign frm.bad = (in_byte != ~sum_q);
	assign frm.current_raw = cur_q;
	assign frm.voltage_raw = vol_q;
	assign frm.power_raw = pow_q;
	assign frm.energy_raw = ene_q;
	assign frm.period_raw = per_q;

endmodule

@@ rtl/core/emfd_back.sv @@
module emfd_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                frm_valid,
	input  emfd_pkg::frame_t    frm,
	output logic                frm_ready,
	input  logic [27:0]         voltage_gain,
	input  logic [27:0]         current_gain,
	input  logic [27:0]         power_gain,
	input  logic [27:0]         energy_gain,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                status,
	output logic [21:0]         v_rms,
	output logic [19:0]         i_rms,
	output logic signed [25:0]  p_active,
	output logic [26:0]         energy_wh,
	output logic [28:0]         f_line
);
	import emfd_pkg::*;

	back_state_t state_q, state_d;
	frame_t      f_q;
	logic [23:0] mag_q;
	logic        neg_q;
	logic [51:0] prod_q;
	logic [4:0]  cnt_q;
	logic [28:0] rem_q, quo_q;
	logic [23:0] op_a;
	logic [27:0] op_g;
	logic [27:0] prod_hi;
	logic [29:0] trial;

	assign frm_ready = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign prod_hi = prod_q[51:24];
	assign trial = {rem_q, quo_q[28]} - {14'd0, f_q.period_raw};

	// Multiplier operand select, one scaled value per state.
	always_comb begin
		op_a = f_q.voltage_raw;
		op_g = voltage_gain;
		case (state_q)
			ST_VOLT: begin op_a = f_q.voltage_raw; op_g = voltage_gain; end
			ST_CURR: begin op_a = f_q.current_raw; op_g = current_gain; end
			ST_POW:  begin op_a = mag_q; op_g = power_gain; end
			ST_ENER: begin op_a = f_q.energy_raw; op_g = energy_gain; end
			default: ;
		endcase
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (frm_valid) state_d = frm.bad ? ST_OUT : ST_VOLT;
			ST_VOLT: state_d = ST_CURR;
			ST_CURR: state_d = ST_POW;
			ST_POW:  state_d = ST_ENER;
			ST_ENER: state_d = ST_DIV;
			ST_DIV:  if (cnt_q == 5'd28) state_d = ST_OUT;
			ST_OUT:  if (!out_stall) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// Datapath: multiply, saturate the previous product, divide bit by bit.
	always_ff @(posedge clk) begin
		prod_q <= op_a * op_g;
		case (state_q)
			ST_IDLE: if (frm_valid) begin
				f_q <= frm;
				neg_q <= frm.power_raw[23];
				mag_q <= frm.power_raw[23] ? (24'd0 - frm.power_raw) : frm.power_raw;
				status <= frm.bad;
				v_rms <= '0; i_rms <= '0; p_active <= '0;
				energy_wh <= '0; f_line <= '0;
			end
			ST_CURR: v_rms <= (prod_hi > 28'(VOLT_MAX)) ? VOLT_MAX : prod_hi[21:0];
			ST_POW:  i_rms <= (prod_hi > 28'(CURR_MAX)) ? CURR_MAX : prod_hi[19:0];
			ST_ENER: begin
				// Power magnitude with zero power special-cased by the sign.
				if (neg_q && mag_q != 24'd0)
					p_active <= (prod_hi > 28'(POW_NEG_MAX)) ? -$signed(POW_NEG_MAX)
						: -$signed(prod_hi[25:0]);
				else
					p_active <= (prod_hi > 28'(POW_POS_MAX)) ? $signed({1'b0, POW_POS_MAX})
						: $signed(prod_hi[25:0]);
				rem_q <= '0;
				quo_q <= FREQ_NUM;
				cnt_q <= '0;
			end
			ST_DIV: begin
				if (cnt_q == 5'd0)
					energy_wh <= (prod_hi > 28'(ENER_MAX)) ? ENER_MAX : prod_hi[26:0];
				if (cnt_q < 5'd29) begin
					if (!trial[29]) begin
						rem_q <= trial[28:0];
						quo_q <= {quo_q[27:0], 1'b1};
					end else begin
						rem_q <= {rem_q[27:0], quo_q[28]};
						quo_q <= {quo_q[27:0], 1'b0};
					end
				end
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd28)
					f_line <= (f_q.period_raw == 16'd0) ? FREQ_ZERO_PERIOD
						: (trial[29] ? {quo_q[27:0], 1'b0} : {quo_q[27:0], 1'b1});
			end
			default: ;
		endcase
	end

endmodule

@@ rtl/core/emfd_queue.sv @@
module emfd_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_valid,
	input  emfd_pkg::frame_t wr_data,
	output logic             rd_valid,
	output emfd_pkg::frame_t rd_data,
	input  logic             rd_ready
);
	import emfd_pkg::*;

	// Two-entry queue decoupling the byte front from the arithmetic back.
	frame_t     mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       wr, rd;

	assign rd_valid = (cnt_q != 2'd0);
	assign rd_data = mem_q[rp_q];
	assign rd = rd_valid && rd_ready;
	assign wr = wr_valid && (cnt_q != 2'd2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
		end else begin
			if (wr) wp_q <= ~wp_q;
			if (rd) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(wr) - 2'(rd);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end

endmodule

@@ rtl/core/energy_meter_frame_decoder.sv @@
// Byte-serial frame decoder for an energy metering link. The front end
// accepts a byte whenever the input is not stalled; a completed frame then
// goes to the back end, which handles one frame at a time (four multiplies and
// a 29-step restoring divide for frequency). A two-frame queue sits between
// them; the byte input stalls only when that queue is full. Gain registers are
// 28-bit Q24 values written by index 0..3 (voltage, current, power, energy).
module energy_meter_frame_decoder #(
	parameter int FRAME_BYTES = emfd_pkg::FRAME_BYTES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         rx_byte,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               status,
	output logic [21:0]        v_rms,
	output logic [19:0]        i_rms,
	output logic signed [25:0] p_active,
	output logic [26:0]        energy_wh,
	output logic [28:0]        f_line,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data
);
	import emfd_pkg::*;

	logic   wr_ok, fr_valid, q_valid, q_ready, q_full;
	frame_t fr, q_data;
	logic   [27:0] vg_q, cg_q, pg_q, eg_q;
	logic   [1:0]  occ_q;

	assign cfg_ready = 1'b1;

	// Gain registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vg_q <= 28'd2267532; cg_q <= 28'd548315;
			pg_q <= 28'd47433463; eg_q <= 28'd102400000;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_VOLTAGE: vg_q <= cfg_data[27:0];
				REG_CURRENT: cg_q <= cfg_data[27:0];
				REG_POWER:   pg_q <= cfg_data[27:0];
				REG_ENERGY:  eg_q <= cfg_data[27:0];
				default: ;
			endcase
		end
	end

	// Stall bytes while the queue is full.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) occ_q <= '0;
		else occ_q <= occ_q + 2'(fr_valid) - 2'(q_valid && q_ready);
	end
	assign q_full = (occ_q == 2'd2);
	assign in_stall = q_full;
	assign wr_ok = in_valid && !in_stall;

	emfd_front #(.FRAME_BYTES(FRAME_BYTES)) u_front (
		.clk, .arst_n, .in_valid(wr_ok), .in_byte(rx_byte),
		.frm_valid(fr_valid), .frm(fr)
	);

	emfd_queue u_queue (
		.clk, .arst_n, .wr_valid(fr_valid), .wr_data(fr),
		.rd_valid(q_valid), .rd_data(q_data), .rd_ready(q_ready)
	);

	emfd_back u_back (
		.clk, .arst_n, .frm_valid(q_valid), .frm(q_data), .frm_ready(q_ready),
		.voltage_gain(vg_q), .current_gain(cg_q), .power_gain(pg_q),
		.energy_gain(eg_q), .out_valid, .out_stall, .status, .v_rms,
		.i_rms, .p_active, .energy_wh, .f_line
	);

endmodule
